[hw/rtl/psfut_pkg.sv]
// Shared types, constants and a helper function for the PSF Unicode table parser.
package psfut_pkg;

  localparam logic [16:0] MAX_GLYPHS    = 17'd65536;
  localparam logic [16:0] GLYPH_RST_CNT = 17'd256;

  localparam logic [0:0] CFG_UTF8_MODE   = 1'b0;
  localparam logic [0:0] CFG_GLYPH_COUNT = 1'b1;

  localparam logic [1:0] SEQ_IDLE   = 2'd0;
  localparam logic [1:0] SEQ_OPEN   = 2'd1;
  localparam logic [1:0] SEQ_MEMBER = 2'd2;

  localparam logic [7:0] UTF8_END    = 8'hff;
  localparam logic [7:0] UTF8_SEQ    = 8'hfe;
  localparam logic [15:0] UCS2_END   = 16'hffff;
  localparam logic [15:0] UCS2_SEQ   = 16'hfffe;

  typedef enum logic [1:0] {
    KIND_NEW = 2'd0,
    KIND_EXT = 2'd1,
    KIND_END = 2'd2,
    KIND_ERR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]  pending;
    logic [30:0] acc;
    logic [7:0]  low_byte;
    logic        half_valid;
    logic [1:0]  seq;
    logic [15:0] glyph;
    logic        err;
    logic        fin;
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] code_point;
    logic [15:0] glyph_index;
    logic        table_done;
  } result_t;

  function automatic logic [16:0] glyph_limit(input logic [16:0] count);
    logic [16:0] lim;
    lim = count;
    if (count == 17'd0) begin
      lim = 17'd1;
    end else if (count > MAX_GLYPHS) begin
      lim = MAX_GLYPHS;
    end
    return lim;
  endfunction

endpackage

[hw/rtl/psfut_if.sv]
// Valid/ready stream interfaces for table bytes and decoded events.
interface psfut_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface psfut_event_if;
  logic                valid;
  logic                ready;
  psfut_pkg::kind_t    kind;
  logic [30:0]         code_point;
  logic [15:0]         glyph_index;
  logic                table_done;

  modport source (output valid, output kind, output code_point, output glyph_index,
                  output table_done, input ready);
  modport sink (input valid, input kind, input code_point, input glyph_index,
                input table_done, output ready);
endinterface

[hw/rtl/psfut_decode.sv]
// Single-pass decoder: one table byte and the parser state give the next state and, when res_valid is set, an event.
module psfut_decode (
  input  logic                utf8_mode,
  input  logic [16:0]         glyph_lim,
  input  logic [7:0]          byte_in,
  input  psfut_pkg::state_t   st,
  output psfut_pkg::state_t   st_nxt,
  output logic                res_valid,
  output psfut_pkg::result_t  res
);

  logic        code_ev;
  logic        end_ev;
  logic        err_ev;
  logic        done;
  logic [30:0] cp;
  logic [30:0] acc_sh;
  logic [15:0] unit;

  assign acc_sh = {st.acc[24:0], byte_in[5:0]};
  assign unit   = {byte_in, st.low_byte};
  assign done   = (({1'b0, st.glyph} + 17'd1) >= glyph_lim);

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    code_ev   = 1'b0;
    end_ev    = 1'b0;
    err_ev    = 1'b0;
    cp        = '0;
    res.kind        = psfut_pkg::KIND_NEW;
    res.code_point  = '0;
    res.glyph_index = st.glyph;
    res.table_done  = 1'b0;

    if (!st.err && !st.fin) begin
      if (utf8_mode) begin
        if (st.pending != 3'd0) begin
          if (byte_in[7:6] != 2'b10) begin
            err_ev = 1'b1;
          end else begin
            st_nxt.pending = st.pending - 3'd1;
            if (st.pending == 3'd1) begin
              code_ev    = 1'b1;
              cp         = acc_sh;
              st_nxt.acc = '0;
            end else begin
              st_nxt.acc = acc_sh;
            end
          end
        end else if (byte_in == psfut_pkg::UTF8_END) begin
          end_ev = 1'b1;
        end else if (byte_in == psfut_pkg::UTF8_SEQ) begin
          st_nxt.seq = psfut_pkg::SEQ_OPEN;
        end else if (byte_in[7] == 1'b0) begin
          code_ev = 1'b1;
          cp      = {23'd0, byte_in};
        end else if (byte_in[6] == 1'b0) begin
          err_ev = 1'b1;
        end else if (byte_in[5] == 1'b0) begin
          st_nxt.pending = 3'd1;
          st_nxt.acc     = {26'd0, byte_in[4:0]};
        end else if (byte_in[4] == 1'b0) begin
          st_nxt.pending = 3'd2;
          st_nxt.acc     = {27'd0, byte_in[3:0]};
        end else if (byte_in[3] == 1'b0) begin
          st_nxt.pending = 3'd3;
          st_nxt.acc     = {28'd0, byte_in[2:0]};
        end else if (byte_in[2] == 1'b0) begin
          st_nxt.pending = 3'd4;
          st_nxt.acc     = {29'd0, byte_in[1:0]};
        end else begin
          st_nxt.pending = 3'd5;
          st_nxt.acc     = {30'd0, byte_in[0]};
        end
      end else begin
        if (!st.half_valid) begin
          st_nxt.low_byte   = byte_in;
          st_nxt.half_valid = 1'b1;
        end else begin
          st_nxt.low_byte   = '0;
          st_nxt.half_valid = 1'b0;
          if (unit == psfut_pkg::UCS2_END) begin
            end_ev = 1'b1;
          end else if (unit == psfut_pkg::UCS2_SEQ) begin
            st_nxt.seq = psfut_pkg::SEQ_OPEN;
          end else begin
            code_ev = 1'b1;
            cp      = {15'd0, unit};
          end
        end
      end

      if (code_ev) begin
        res_valid      = 1'b1;
        res.kind       = (st.seq >= psfut_pkg::SEQ_MEMBER) ? psfut_pkg::KIND_EXT
                                                           : psfut_pkg::KIND_NEW;
        res.code_point = cp;
        if (st.seq == psfut_pkg::SEQ_OPEN) begin
          st_nxt.seq = psfut_pkg::SEQ_MEMBER;
        end
      end
      if (end_ev) begin
        res_valid      = 1'b1;
        res.kind       = psfut_pkg::KIND_END;
        res.table_done = done;
        st_nxt.seq     = psfut_pkg::SEQ_IDLE;
        if (done) begin
          st_nxt.fin = 1'b1;
        end else begin
          st_nxt.glyph = st.glyph + 16'd1;
        end
      end
      if (err_ev) begin
        res_valid      = 1'b1;
        res.kind       = psfut_pkg::KIND_ERR;
        st_nxt.err     = 1'b1;
        st_nxt.pending = 3'd0;
        st_nxt.acc     = '0;
      end
    end
  end

endmodule

[hw/rtl/psf_unicode_table_parser.sv]
// Top level of the PSF Unicode table parser: input register, decoder, result register.
//
//   Channel   Direction  Contents
//   in_ch     sink       byte_in: one raw byte of the Unicode table
//   out_ch    source     kind, code_point, glyph_index, table_done
//   cfg_*     write      index 0 utf8_mode, index 1 glyph_count
//
// A byte transferred at one edge sits in the input register, goes through the decoder
// and its event, if any, then reaches the result register. One byte is accepted per cycle unless the result stalls.
// rst_n is synchronous and active low; a configuration write restarts parsing.
// A stalled result holds the decoder and the input register; the input side
// keeps accepting while the input register is empty or about to move.
module psf_unicode_table_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  psfut_byte_if.sink           in_ch,
  psfut_event_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [16:0]          cfg_data
);

  logic                 in_v_r;
  logic [7:0]           in_byte_r;
  logic                 utf8_mode_r;
  logic [16:0]          glyph_lim_r;
  psfut_pkg::state_t    st_r;
  psfut_pkg::state_t    st_nxt;
  logic                 res_valid;
  psfut_pkg::result_t   res;
  logic                 out_v_r;
  psfut_pkg::result_t   out_res_r;
  logic                 advance;
  logic                 in_ready;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ready    = !in_v_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_byte_r <= in_ch.byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_mode_r <= 1'b1;
      glyph_lim_r <= psfut_pkg::GLYPH_RST_CNT;
    end else if (cfg_we) begin
      case (cfg_index)
        psfut_pkg::CFG_UTF8_MODE: begin
          utf8_mode_r <= cfg_data[0];
        end
        psfut_pkg::CFG_GLYPH_COUNT: begin
          glyph_lim_r <= psfut_pkg::glyph_limit(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  psfut_decode u_decode (
    .utf8_mode (utf8_mode_r),
    .glyph_lim (glyph_lim_r),
    .byte_in   (in_byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res_valid;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.code_point  = out_res_r.code_point;
  assign out_ch.glyph_index = out_res_r.glyph_index;
  assign out_ch.table_done  = out_res_r.table_done;

endmodule

[hw/rtl/psfut_checker.sv]
// Port-level assertions for the PSF Unicode table parser and their bind.
module psfut_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input psfut_pkg::kind_t  out_kind,
  input logic [30:0]       out_code_point,
  input logic [15:0]       out_glyph_index,
  input logic              out_table_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_code_point) &&
                                $stable(out_glyph_index) && $stable(out_table_done))
    else $error("result changed while stalled");

  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == psfut_pkg::KIND_END || out_kind == psfut_pkg::KIND_ERR)
      |-> out_code_point == 31'd0)
    else $error("code point set on a list end or error");

  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_done |-> out_kind == psfut_pkg::KIND_END)
    else $error("table done flag on a non list end transfer");

endmodule

bind psf_unicode_table_parser psfut_checker u_psfut_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_code_point  (out_ch.code_point),
  .out_glyph_index (out_ch.glyph_index),
  .out_table_done  (out_ch.table_done)
);

[tb/tb_top.sv]
// Self-checking testbench for the PSF Unicode table parser: directed rows, then random tables.
module tb_top;

  localparam int RANDOM_ITEMS  = 1200;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic               is_write;
    logic [0:0]         reg_sel;
    logic [16:0]        value;
    logic               typed;
    psfut_pkg::result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_data;

  psfut_byte_if  bytes_ch();
  psfut_event_if events_ch();

  psf_unicode_table_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (bytes_ch),
    .out_ch    (events_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Decoder state mirrored by the testbench.
  logic        mode_utf8;
  logic [16:0] glyph_total;
  logic [2:0]  cont_left;
  logic [30:0] partial;
  logic [7:0]  held_low;
  logic        held_ok;
  logic [1:0]  seq_pos;
  logic [15:0] glyph_now;
  logic        stuck_err;
  logic        table_over;

  psfut_pkg::result_t expected_events[$];
  int      mismatches = 0;
  int      live_items = 0;
  int      src_idle_pct;
  int      sink_idle_pct;
  logic    hold_request;
  logic    results_held;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[psf_unicode_table_parser] ERROR");
    $finish;
  end

  function automatic void restart_parse();
    cont_left  = '0;
    partial    = '0;
    held_low   = '0;
    held_ok    = 1'b0;
    seq_pos    = psfut_pkg::SEQ_IDLE;
    glyph_now  = '0;
    stuck_err  = 1'b0;
    table_over = 1'b0;
  endfunction

  function automatic psfut_pkg::result_t code_event(input logic [30:0] cp);
    psfut_pkg::result_t ev;
    ev.kind        = (seq_pos == psfut_pkg::SEQ_MEMBER) ? psfut_pkg::KIND_EXT
                                                        : psfut_pkg::KIND_NEW;
    ev.code_point  = cp;
    ev.glyph_index = glyph_now;
    ev.table_done  = 1'b0;
    if (seq_pos == psfut_pkg::SEQ_OPEN) begin
      seq_pos = psfut_pkg::SEQ_MEMBER;
    end
    return ev;
  endfunction

  function automatic psfut_pkg::result_t end_event();
    psfut_pkg::result_t ev;
    logic [16:0]        limit;
    limit = glyph_total;
    if (glyph_total == 17'd0) begin
      limit = 17'd1;
    end else if (glyph_total > psfut_pkg::MAX_GLYPHS) begin
      limit = psfut_pkg::MAX_GLYPHS;
    end
    ev.kind        = psfut_pkg::KIND_END;
    ev.code_point  = '0;
    ev.glyph_index = glyph_now;
    ev.table_done  = ({1'b0, glyph_now} + 17'd1 >= limit);
    seq_pos = psfut_pkg::SEQ_IDLE;
    if (ev.table_done) begin
      table_over = 1'b1;
    end else begin
      glyph_now = glyph_now + 16'd1;
    end
    return ev;
  endfunction

  function automatic psfut_pkg::result_t err_event();
    psfut_pkg::result_t ev;
    ev.kind        = psfut_pkg::KIND_ERR;
    ev.code_point  = '0;
    ev.glyph_index = glyph_now;
    ev.table_done  = 1'b0;
    stuck_err = 1'b1;
    cont_left = '0;
    partial   = '0;
    return ev;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output psfut_pkg::result_t ev);
    int          ones;
    logic [15:0] unit;
    ev = '0;
    if (stuck_err || table_over) begin
      return 1'b0;
    end
    if (mode_utf8) begin
      if (cont_left != 3'd0) begin
        if (b[7:6] != 2'b10) begin
          ev = err_event();
          return 1'b1;
        end
        partial   = {partial[24:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left != 3'd0) begin
          return 1'b0;
        end
        ev      = code_event(partial);
        partial = '0;
        return 1'b1;
      end
      if (b == psfut_pkg::UTF8_END) begin
        ev = end_event();
        return 1'b1;
      end
      if (b == psfut_pkg::UTF8_SEQ) begin
        seq_pos = psfut_pkg::SEQ_OPEN;
        return 1'b0;
      end
      ones = 0;
      while (ones < 8 && b[7 - ones]) begin
        ones++;
      end
      if (ones == 0) begin
        ev = code_event({23'd0, b});
        return 1'b1;
      end
      if (ones == 1) begin
        ev = err_event();
        return 1'b1;
      end
      partial   = {23'd0, b & ((8'h80 >> ones) - 8'd1)};
      cont_left = 3'(ones - 1);
      return 1'b0;
    end
    if (!held_ok) begin
      held_low = b;
      held_ok  = 1'b1;
      return 1'b0;
    end
    unit     = {b, held_low};
    held_ok  = 1'b0;
    held_low = '0;
    if (unit == psfut_pkg::UCS2_END) begin
      ev = end_event();
      return 1'b1;
    end
    if (unit == psfut_pkg::UCS2_SEQ) begin
      seq_pos = psfut_pkg::SEQ_OPEN;
      return 1'b0;
    end
    ev = code_event({15'd0, unit});
    return 1'b1;
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] b);
    stim_row_t row;
    row       = '0;
    row.value = {9'd0, b};
    return row;
  endfunction

  function automatic stim_row_t event_row(input logic [7:0] b, input psfut_pkg::kind_t kind,
                                          input logic [30:0] cp, input logic [15:0] glyph,
                                          input logic done);
    stim_row_t row;
    row                  = byte_row(b);
    row.typed            = 1'b1;
    row.want.kind        = kind;
    row.want.code_point  = cp;
    row.want.glyph_index = glyph;
    row.want.table_done  = done;
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [0:0] sel, input logic [16:0] value);
    stim_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.reg_sel  = sel;
    row.value    = value;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input psfut_pkg::result_t want);
    psfut_pkg::result_t ev;
    bit                 made;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(negedge clk);
    end
    bytes_ch.valid   <= 1'b1;
    bytes_ch.byte_in <= b;
    do @(posedge clk); while (!bytes_ch.ready);
    if (!stuck_err && !table_over) begin
      live_items++;
    end
    made = decode_byte(b, ev);
    if (typed) begin
      expected_events.push_back(want);
    end else if (made) begin
      expected_events.push_back(ev);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] sel, input logic [16:0] value);
    bytes_ch.valid <= 1'b0;
    while (expected_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == psfut_pkg::CFG_UTF8_MODE) begin
      mode_utf8 = value[0];
    end else begin
      glyph_total = value;
    end
    restart_parse();
    @(negedge clk);
  endtask

  // One table token: mostly well-formed code points, markers and list ends, a little noise.
  task automatic send_token();
    int          pick;
    int          len;
    int          nbits;
    logic [30:0] cp;
    logic [30:0] rest;
    logic [15:0] unit;
    logic [7:0]  tail [6];
    pick = $urandom_range(0, 99);
    if (!mode_utf8) begin
      if (pick < 60) begin
        unit = 16'($urandom);
      end else if (pick < 72) begin
        unit = psfut_pkg::UCS2_SEQ;
      end else if (pick < 87) begin
        unit = psfut_pkg::UCS2_END;
      end else begin
        send_byte(8'($urandom), 1'b0, '0);
        return;
      end
      send_byte(unit[7:0], 1'b0, '0);
      send_byte(unit[15:8], 1'b0, '0);
      return;
    end
    if (pick < 15) begin
      send_byte(psfut_pkg::UTF8_END, 1'b0, '0);
    end else if (pick < 25) begin
      send_byte(psfut_pkg::UTF8_SEQ, 1'b0, '0);
    end else if (pick >= 97) begin
      send_byte(8'($urandom), 1'b0, '0);
    end else begin
      pick = $urandom_range(0, 19);
      len  = (pick < 7) ? 1 : (pick < 12) ? 2 : (pick < 16) ? 3 :
             (pick < 18) ? 4 : (pick < 19) ? 5 : 6;
      nbits = (len == 1) ? 7 : 5 * len + 1;
      cp    = 31'($urandom) & ((31'd1 << nbits) - 31'd1);
      rest  = cp;
      for (int k = len - 1; k >= 1; k--) begin
        tail[k] = {2'b10, rest[5:0]};
        rest    = rest >> 6;
      end
      tail[0] = (len == 1) ? rest[7:0] :
                ((8'hff << (8 - len)) | (rest[7:0] & (8'hff >> (len + 1))));
      for (int k = 0; k < len; k++) begin
        send_byte(tail[k], 1'b0, '0);
      end
    end
  endtask

  initial begin
    events_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      events_ch.ready <= !results_held && ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  initial begin
    results_held = 1'b0;
    wait (hold_request);
    @(posedge clk);
    results_held <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    results_held <= 1'b0;
  end

  always @(posedge clk) begin : check_events
    psfut_pkg::result_t want;
    if (rst_n && events_ch.valid && events_ch.ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected event: kind %0d cp %0h glyph %0d done %0b",
                   events_ch.kind, events_ch.code_point, events_ch.glyph_index,
                   events_ch.table_done);
        end
      end else begin
        want = expected_events.pop_front();
        if (events_ch.kind !== want.kind || events_ch.code_point !== want.code_point ||
            events_ch.glyph_index !== want.glyph_index ||
            events_ch.table_done !== want.table_done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("event mismatch: expected kind %0d cp %0h glyph %0d done %0b",
                     want.kind, want.code_point, want.glyph_index, want.table_done);
            $display("                got      kind %0d cp %0h glyph %0d done %0b",
                     events_ch.kind, events_ch.code_point, events_ch.glyph_index,
                     events_ch.table_done);
          end
        end
      end
    end
  end

  initial begin
    stim_row_t   directed_rows [29];
    logic [16:0] phase_counts [10];
    logic [16:0] count_sel;
    logic        mode_sel;
    int          phase;
    int          budget;
    int          first_live;
    int          phase_start;
    int          progress;
    int          wait_cycles;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = psfut_pkg::CFG_UTF8_MODE;
    cfg_data         = '0;
    bytes_ch.valid   = 1'b0;
    bytes_ch.byte_in = '0;
    hold_request     = 1'b0;
    src_idle_pct     = 6;
    sink_idle_pct    = 81;
    mode_utf8        = 1'b1;
    glyph_total      = psfut_pkg::GLYPH_RST_CNT;
    restart_parse();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_rows = '{
      event_row(8'h00, psfut_pkg::KIND_NEW, 31'h0, 16'd0, 1'b0),
      event_row(8'h7f, psfut_pkg::KIND_NEW, 31'h7f, 16'd0, 1'b0),
      byte_row(8'hc3), byte_row(8'ha9),
      byte_row(psfut_pkg::UTF8_SEQ), byte_row(8'h41),
      byte_row(8'he2), byte_row(8'h82), byte_row(8'hac),
      event_row(psfut_pkg::UTF8_END, psfut_pkg::KIND_END, 31'h0, 16'd0, 1'b0),
      byte_row(8'hfd), byte_row(8'hbf), byte_row(8'hbf), byte_row(8'hbf), byte_row(8'hbf),
      event_row(8'hbf, psfut_pkg::KIND_NEW, 31'h7fffffff, 16'd1, 1'b0),
      event_row(8'h80, psfut_pkg::KIND_ERR, 31'h0, 16'd1, 1'b0),
      byte_row(8'h41),
      write_row(psfut_pkg::CFG_GLYPH_COUNT, 17'd0),
      byte_row(8'hc3),
      event_row(psfut_pkg::UTF8_END, psfut_pkg::KIND_ERR, 31'h0, 16'd0, 1'b0),
      write_row(psfut_pkg::CFG_UTF8_MODE, 17'd0),
      byte_row(8'h41), byte_row(8'h00),
      byte_row(8'hfe), byte_row(8'hff),
      byte_row(8'hff),
      event_row(8'hff, psfut_pkg::KIND_END, 31'h0, 16'd0, 1'b1),
      byte_row(8'h00)
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                  directed_rows[i].want);
      end
    end

    phase_counts = '{17'd3, 17'd1, 17'd131071, 17'd0, 17'd2,
                     17'd65536, 17'd5, 17'd256, 17'd12, 17'd7};
    first_live = live_items;
    phase      = 0;
    while (live_items - first_live < RANDOM_ITEMS) begin
      progress = live_items - first_live;
      if (progress < RANDOM_ITEMS / 3) begin
        src_idle_pct  = 6;
        sink_idle_pct = 81;
      end else if (progress < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 81;
        sink_idle_pct = 6;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (phase < 10) begin
        mode_sel  = phase[0];
        count_sel = phase_counts[phase];
      end else begin
        mode_sel  = 1'($urandom_range(0, 1));
        count_sel = 17'($urandom_range(1, 20));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(psfut_pkg::CFG_UTF8_MODE, {16'($urandom), mode_sel});
        write_reg(psfut_pkg::CFG_GLYPH_COUNT, count_sel);
      end else begin
        write_reg(psfut_pkg::CFG_GLYPH_COUNT, count_sel);
        write_reg(psfut_pkg::CFG_UTF8_MODE, {16'($urandom), mode_sel});
      end
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      budget      = $urandom_range(30, 150);
      phase_start = live_items;
      while (live_items - phase_start < budget && !stuck_err && !table_over) begin
        send_token();
      end
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
      phase++;
    end

    bytes_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (expected_events.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("[psf_unicode_table_parser] OK");
    end else begin
      $display("[psf_unicode_table_parser] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/psfut_pkg.sv
hw/rtl/psfut_if.sv
hw/rtl/psfut_decode.sv
hw/rtl/psf_unicode_table_parser.sv
hw/rtl/psfut_checker.sv
tb/tb_top.sv
